// ===== design/kss_pkg.sv =====
package kss_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int RANK_BITS    = 7;
    localparam int COMMAND_BITS = 2;
    localparam int STATUS_BITS  = 2;

    localparam logic [COMMAND_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [COMMAND_BITS-1:0] CMD_LOAD   = 2'd1;
    localparam logic [COMMAND_BITS-1:0] CMD_SELECT = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_SELECTED = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD_RANK = 2'd3;

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic [COMMAND_BITS-1:0]    command;
        logic signed [VALUE_BITS-1:0] value;
        logic [RANK_BITS-1:0]       rank;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_BITS-1:0]     status;
        logic signed [VALUE_BITS-1:0] selected;
    } t_out_word;

endpackage

// ===== design/kss_ram.sv =====
module kss_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/kth_smallest_select.sv =====
// Holds up to STORE_DEPTH signed values and returns the rank-th smallest on a select
// command. Clear and load may come back to back; their word appears on o_result with
// o_done in the cycle after start. A select whose rank is zero or above the number of
// loaded values answers the same way, without going busy. Any other select runs
// quickselect with busy high. Every key examined is read through the store's single
// read port, and each swap writes both of its slots in turn. Each partition pass also
// fetches its pivot and then places it. A select is slowest when the data is already
// ordered. The result word is shown for exactly one cycle; the receiver must take it then.
// Selection leaves the store permuted.
module kth_smallest_select #(
    parameter int STORE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  kss_pkg::t_in_word  i_item,
    output logic               o_done,
    output kss_pkg::t_out_word o_result
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int WW = (CW > kss_pkg::RANK_BITS) ? CW : kss_pkg::RANK_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RANGE = 4'd1;
    localparam logic [3:0] S_PIV   = 4'd2;
    localparam logic [3:0] S_LRD   = 4'd3;
    localparam logic [3:0] S_LCMP  = 4'd4;
    localparam logic [3:0] S_RRD   = 4'd5;
    localparam logic [3:0] S_RCMP  = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_SW2   = 4'd8;
    localparam logic [3:0] S_X1    = 4'd9;
    localparam logic [3:0] S_X2    = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_right, n_right;
    logic [CW-1:0]       r_want, n_want;
    kss_pkg::t_value     r_pivot, n_pivot;
    kss_pkg::t_value     r_vl, n_vl;
    kss_pkg::t_value     r_vr, n_vr;
    logic                r_done, n_done;
    kss_pkg::t_out_word  r_res, n_res;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    kss_pkg::t_value     ram_wdata;
    logic [AW-1:0]       ram_raddr;
    kss_pkg::t_value     ram_rdata;

    logic                accept;
    logic [WW-1:0]       rank_ext;
    logic [WW-1:0]       count_ext;
    logic [CW-1:0]       part_rank;

    kss_ram #(
        .WIDTH (kss_pkg::VALUE_BITS),
        .DEPTH (STORE_DEPTH),
        .ADDR_BITS (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign rank_ext  = WW'(i_item.rank);
    assign count_ext = WW'(r_count);
    assign part_rank = r_right - r_lo + CW'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_left    = r_left;
        n_right   = r_right;
        n_want    = r_want;
        n_pivot   = r_pivot;
        n_vl      = r_vl;
        n_vr      = r_vr;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_lo[AW-1:0];
        ram_wdata = r_vr;
        ram_raddr = r_lo[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done         = 1'b1;
                    n_res.status   = kss_pkg::ST_DONE;
                    n_res.selected = '0;
                    case (i_item.command)
                        kss_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        kss_pkg::CMD_LOAD: begin
                            if (r_count < CW'(STORE_DEPTH)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_item.value;
                                n_count   = r_count + CW'(1);
                            end else begin
                                n_res.status = kss_pkg::ST_FULL;
                            end
                        end
                        kss_pkg::CMD_SELECT: begin
                            if (r_count == '0 || rank_ext == '0 || rank_ext > count_ext) begin
                                n_res.status = kss_pkg::ST_BAD_RANK;
                            end else begin
                                n_done  = 1'b0;
                                n_lo    = '0;
                                n_hi    = r_count - CW'(1);
                                n_want  = CW'(i_item.rank);
                                n_state = S_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RANGE: begin
                ram_raddr = r_lo[AW-1:0];
                n_state   = (r_lo >= r_hi) ? S_FIN : S_PIV;
            end
            S_PIV: begin
                n_pivot = ram_rdata;
                n_left  = r_lo + CW'(1);
                n_right = r_hi;
                n_state = S_LRD;
            end
            S_LRD: begin
                ram_raddr = r_left[AW-1:0];
                n_state   = (r_left <= r_right) ? S_LCMP : S_RRD;
            end
            S_LCMP: begin
                if ($signed(ram_rdata) < $signed(r_pivot)) begin
                    n_left  = r_left + CW'(1);
                    n_state = S_LRD;
                end else begin
                    n_vl    = ram_rdata;
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                ram_raddr = r_right[AW-1:0];
                if (r_right > r_lo) begin
                    n_state = S_RCMP;
                end else begin
                    n_vr    = r_pivot;
                    n_state = S_CHK;
                end
            end
            S_RCMP: begin
                if ($signed(r_pivot) < $signed(ram_rdata)) begin
                    n_right = r_right - CW'(1);
                    n_state = S_RRD;
                end else begin
                    n_vr    = ram_rdata;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_left >= r_right) begin
                    n_state = S_X1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_left[AW-1:0];
                    ram_wdata = r_vr;
                    n_state   = S_SW2;
                end
            end
            S_SW2: begin
                ram_we    = 1'b1;
                ram_waddr = r_right[AW-1:0];
                ram_wdata = r_vl;
                n_left    = r_left + CW'(1);
                n_right   = r_right - CW'(1);
                n_state   = S_LRD;
            end
            S_X1: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[AW-1:0];
                ram_wdata = r_vr;
                n_state   = S_X2;
            end
            S_X2: begin
                ram_we    = 1'b1;
                ram_waddr = r_right[AW-1:0];
                ram_wdata = r_pivot;
                if (r_want < part_rank) begin
                    n_hi    = r_right - CW'(1);
                    n_state = S_RANGE;
                end else if (r_want == part_rank) begin
                    n_done         = 1'b1;
                    n_res.status   = kss_pkg::ST_SELECTED;
                    n_res.selected = r_pivot;
                    n_state        = S_IDLE;
                end else begin
                    n_want  = r_want - part_rank;
                    n_lo    = r_right + CW'(1);
                    n_state = S_RANGE;
                end
            end
            S_FIN: begin
                n_done         = 1'b1;
                n_res.status   = kss_pkg::ST_SELECTED;
                n_res.selected = ram_rdata;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_done  <= n_done;
        end
        r_left  <= n_left;
        r_right <= n_right;
        r_want  <= n_want;
        r_pivot <= n_pivot;
        r_vl    <= n_vl;
        r_vr    <= n_vr;
        r_res   <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 64;
    localparam logic [kss_pkg::COMMAND_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam longint LIMIT_CYCLES = 100_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 450;

    typedef enum int {
        FILL_RANDOM,
        FILL_CLUSTERED,
        FILL_ASCENDING,
        FILL_DESCENDING,
        FILL_CONSTANT
    } t_fill;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    kss_pkg::t_in_word  i_item;
    logic               o_done;
    kss_pkg::t_out_word o_result;

    logic signed [kss_pkg::VALUE_BITS-1:0] model_store [STORE_DEPTH];
    int                 stored_count;
    kss_pkg::t_out_word expected_words [$];
    int                 fail_count;
    int                 sent_items;
    int                 idle_pct;
    longint             cycle_count;

    kth_smallest_select #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void swap_entries(int a, int b);
        logic signed [kss_pkg::VALUE_BITS-1:0] held;
        held = model_store[a];
        model_store[a] = model_store[b];
        model_store[b] = held;
    endfunction

    // pivot is the first key of the range, returns its final slot
    function automatic int split_around_first(int lo, int hi);
        logic signed [kss_pkg::VALUE_BITS-1:0] pivot;
        int left;
        int right;
        pivot = model_store[lo];
        left = lo + 1;
        right = hi;
        forever begin
            while (left <= right && model_store[left] < pivot) left++;
            while (right > lo && pivot < model_store[right]) right--;
            if (left >= right) break;
            swap_entries(left, right);
            left++;
            right--;
        end
        swap_entries(lo, right);
        return right;
    endfunction

    function automatic kss_pkg::t_out_word predict_result(kss_pkg::t_in_word w);
        kss_pkg::t_out_word r;
        int want;
        int lo;
        int hi;
        int p;
        int span;
        r = '0;
        r.status = kss_pkg::ST_DONE;
        case (w.command)
            kss_pkg::CMD_CLEAR: begin
                stored_count = 0;
            end
            kss_pkg::CMD_LOAD: begin
                if (stored_count < STORE_DEPTH) begin
                    model_store[stored_count] = w.value;
                    stored_count++;
                end else begin
                    r.status = kss_pkg::ST_FULL;
                end
            end
            kss_pkg::CMD_SELECT: begin
                want = int'(w.rank);
                if (stored_count == 0 || want == 0 || want > stored_count) begin
                    r.status = kss_pkg::ST_BAD_RANK;
                end else begin
                    lo = 0;
                    hi = stored_count - 1;
                    forever begin
                        if (lo >= hi) begin
                            r.selected = model_store[lo];
                            break;
                        end
                        p = split_around_first(lo, hi);
                        span = p - lo + 1;
                        if (want < span) begin
                            hi = p - 1;
                        end else if (want == span) begin
                            r.selected = model_store[p];
                            break;
                        end else begin
                            want -= span;
                            lo = p + 1;
                        end
                    end
                    r.status = kss_pkg::ST_SELECTED;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic kss_pkg::t_in_word make_word(logic [kss_pkg::COMMAND_BITS-1:0] cmd,
                                                    logic [kss_pkg::VALUE_BITS-1:0] value,
                                                    int rank);
        kss_pkg::t_in_word w;
        w.command = cmd;
        w.value = value;
        w.rank = kss_pkg::RANK_BITS'(rank);
        return w;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input kss_pkg::t_in_word w);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_words.push_back(predict_result(w));
        if (w.command != CMD_UNUSED) sent_items++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        kss_pkg::t_out_word want_word;
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected word, expected none, actual status %0d selected %0d",
                         $time, o_result.status, $signed(o_result.selected));
            end else begin
                want_word = expected_words.pop_front();
                if (o_result.status !== want_word.status) begin
                    fail_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want_word.status, o_result.status);
                end
                if (o_result.selected !== want_word.selected) begin
                    fail_count++;
                    $display("%0t: selected mismatch, expected %0d, actual %0d",
                             $time, $signed(want_word.selected), $signed(o_result.selected));
                end
            end
        end
    end

    task automatic test_empty_and_unused();
        send_word(make_word(kss_pkg::CMD_SELECT, $urandom, 1));
        send_word(make_word(CMD_UNUSED, $urandom, $urandom_range(0, 64)));
    endtask

    task automatic test_extreme_values();
        send_word(make_word(kss_pkg::CMD_CLEAR, $urandom, 0));
        send_word(make_word(kss_pkg::CMD_LOAD, 32'h7FFF_FFFF, 0));
        send_word(make_word(kss_pkg::CMD_LOAD, 32'h8000_0000, 0));
        send_word(make_word(kss_pkg::CMD_LOAD, 32'h0000_0000, 0));
        send_word(make_word(kss_pkg::CMD_LOAD, 32'hFFFF_FFFF, 0));
        send_word(make_word(kss_pkg::CMD_LOAD, 32'h0000_0001, 0));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 0));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 1));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 5));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 6));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 3));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 64));
    endtask

    task automatic test_duplicate_keys();
        send_word(make_word(kss_pkg::CMD_CLEAR, 0, 0));
        repeat (3) send_word(make_word(kss_pkg::CMD_LOAD, 32'hFFFF_FFFB, 0));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 2));
        send_word(make_word(kss_pkg::CMD_CLEAR, 0, 0));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 1));
    endtask

    task automatic test_full_store();
        send_word(make_word(kss_pkg::CMD_CLEAR, 0, 0));
        repeat (STORE_DEPTH) send_word(make_word(kss_pkg::CMD_LOAD, $urandom, 0));
        repeat (2) send_word(make_word(kss_pkg::CMD_LOAD, $urandom, 0));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 64));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, 1));
        send_word(make_word(kss_pkg::CMD_SELECT, 0, $urandom_range(1, 64)));
    endtask

    // usually clear, fill with a pattern, then query ranks; some noise mixed in
    task automatic test_random_sets(input int idle, input int quota);
        int    first_count;
        int    fill;
        int    queries;
        int    rank;
        int    step;
        t_fill fill_kind;
        logic signed [kss_pkg::VALUE_BITS-1:0] base;
        logic signed [kss_pkg::VALUE_BITS-1:0] v;
        idle_pct = idle;
        first_count = sent_items;
        while (sent_items - first_count < quota) begin
            case ($urandom_range(0, 19))
                0:       fill = STORE_DEPTH;
                1, 2:    fill = $urandom_range(17, STORE_DEPTH - 1);
                default: fill = $urandom_range(1, 16);
            endcase
            fill_kind = t_fill'($urandom_range(0, 4));
            base = $urandom;
            step = $urandom_range(0, 50);
            if ($urandom_range(0, 9) != 0) begin
                send_word(make_word(kss_pkg::CMD_CLEAR, $urandom, 0));
            end
            for (int idx = 0; idx < fill; idx++) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_word(make_word(kss_pkg::COMMAND_BITS'($urandom_range(0, 3)), $urandom,
                                        $urandom_range(0, 64)));
                end
                case (fill_kind)
                    FILL_RANDOM:     v = $urandom;
                    FILL_CLUSTERED:  v = int'($urandom_range(0, 6)) - 3;
                    FILL_ASCENDING:  v = base + idx * step;
                    FILL_DESCENDING: v = base - idx * step;
                    default:         v = base;
                endcase
                send_word(make_word(kss_pkg::CMD_LOAD, v, 0));
            end
            queries = $urandom_range(1, 4);
            repeat (queries) begin
                if ($urandom_range(0, 7) == 0 || stored_count == 0) begin
                    rank = $urandom_range(0, 64);
                end else begin
                    rank = $urandom_range(1, stored_count);
                end
                send_word(make_word(kss_pkg::CMD_SELECT, $urandom, rank));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        stored_count = 0;
        fail_count = 0;
        sent_items = 0;
        idle_pct = 14;
        cycle_count = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_unused();
        test_extreme_values();
        test_duplicate_keys();
        test_full_store();
        test_random_sets(14, PHASE_ITEMS);
        test_random_sets(71, PHASE_ITEMS);
        test_random_sets(0, PHASE_ITEMS);

        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/kss_pkg.sv
design/kss_ram.sv
design/kth_smallest_select.sv
sim/tb.sv
